[design/u16u8_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_LIM  = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIM  = 16'h0800;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] CONT  = 8'h80;

  // one encoded code unit: bytes in send order, byte count minus one
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
  } seq_t;

endpackage

[design/utf16_to_utf8_encoder.sv]
// Top level of the UTF-16 to UTF-8 encoder.
// Takes one 16-bit UTF-16 code unit per input beat and returns its UTF-8 encoding one byte per
// output beat, with out_last_byte on the final byte of each unit. A high surrogate is held and
// yields no bytes; a following low surrogate completes a 4-byte sequence. Other units give 1 to
// 3 bytes; in_last_of_message drops any held high surrogate after the unit. Bytes leave at one per
// cycle while the receiver pops, so the single-byte output register bounds throughput. A two-entry
// sequence queue between the front end and the byte serializer absorbs output stalls, so new units
// are accepted while earlier bytes drain until it is full; a unit's bytes pass through a queue entry
// and then the registered output byte.
module utf16_to_utf8_encoder import u16u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_utf8_byte,
  output logic        out_last_byte
);

  logic q_push, q_full, q_pop, q_empty;
  seq_t q_data, q_head;

  assign full = q_full;

  u16u8_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (push),
    .in_code_unit       (in_code_unit),
    .in_last_of_message (in_last_of_message),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_data)
  );

  u16u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  u16u8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (empty),
    .out_pop       (pop),
    .out_utf8_byte (out_utf8_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

[design/u16u8_front.sv]
// Front end: accepts code units, tracks the pending high surrogate, builds byte sequences.
module u16u8_front import u16u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_of_message,
  input  logic        q_full,
  output logic        q_push,
  output seq_t        q_data
);

  logic [9:0] pend_high_r, pend_high_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic       accept, is_high, is_low, pair;
  logic [20:0] cp;

  assign accept  = in_push && !q_full;
  assign is_high = (in_code_unit >= HI_SURR_FIRST) && (in_code_unit <= HI_SURR_LAST);
  assign is_low  = (in_code_unit >= LO_SURR_FIRST) && (in_code_unit <= LO_SURR_LAST);
  assign pair    = is_low && pend_valid_r;
  assign cp      = SUPP_BASE + {1'b0, pend_high_r, in_code_unit[9:0]};
  assign q_push  = accept && !is_high;

  always_comb begin
    q_data = '0;
    if (pair) begin
      q_data.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
      q_data.bytes[1] = CONT | {2'd0, cp[17:12]};
      q_data.bytes[2] = CONT | {2'd0, cp[11:6]};
      q_data.bytes[3] = CONT | {2'd0, cp[5:0]};
      q_data.cnt_m1   = 2'd3;
    end else if (in_code_unit < ONE_BYTE_LIM) begin
      q_data.bytes[0] = in_code_unit[7:0];
      q_data.cnt_m1   = 2'd0;
    end else if (in_code_unit < TWO_BYTE_LIM) begin
      q_data.bytes[0] = LEAD2 | {3'd0, in_code_unit[10:6]};
      q_data.bytes[1] = CONT | {2'd0, in_code_unit[5:0]};
      q_data.cnt_m1   = 2'd1;
    end else begin
      q_data.bytes[0] = LEAD3 | {4'd0, in_code_unit[15:12]};
      q_data.bytes[1] = CONT | {2'd0, in_code_unit[11:6]};
      q_data.bytes[2] = CONT | {2'd0, in_code_unit[5:0]};
      q_data.cnt_m1   = 2'd2;
    end
  end

  always_comb begin
    pend_high_nxt  = pend_high_r;
    pend_valid_nxt = pend_valid_r;
    if (accept) begin
      if (is_high) begin
        pend_high_nxt  = in_code_unit[9:0];
        pend_valid_nxt = 1'b1;
      end else if (pair) begin
        pend_high_nxt  = '0;
        pend_valid_nxt = 1'b0;
      end
      if (in_last_of_message) begin
        pend_high_nxt  = '0;
        pend_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_high_r  <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      pend_high_r  <= pend_high_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  a_high_stored: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_high && !in_last_of_message |=> pend_valid_r)
    else $error("high surrogate not stored");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_of_message |=> !pend_valid_r)
    else $error("pending surrogate survived end of message");

  a_pair_is_four: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && pair |-> q_data.cnt_m1 == 2'd3)
    else $error("surrogate pair not encoded as four bytes");

endmodule

[design/u16u8_queue.sv]
// Short queue of encoded sequences between front and back ends.
module u16u8_queue import u16u8_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  seq_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output seq_t head
);

  seq_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> !empty)
    else $error("queue empty after push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers inconsistent with count");

endmodule

[design/u16u8_back.sv]
// Back end: serializes queued sequences into a registered one-byte output.
module u16u8_back import u16u8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  seq_t       q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_utf8_byte,
  output logic       out_last_byte
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load, at_end;

  assign at_end = (idx_r == q_head.cnt_m1);
  assign load   = !q_empty && (!vld_r || out_pop);
  assign q_pop  = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= q_head.bytes[idx_r];
      last_r <= at_end;
    end
  end

  assign out_empty     = !vld_r;
  assign out_utf8_byte = byte_r;
  assign out_last_byte = last_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !out_empty)
    else $error("loaded beat not presented");

  a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == 2'd0)
    else $error("byte index not rewound after sequence");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r <= q_head.cnt_m1)
    else $error("byte index past sequence end");

endmodule

[dv/tb_utf16_to_utf8_encoder.sv]
// Testbench for the UTF-16 to UTF-8 encoder: directed and random code units, byte-level check.
`timescale 1ns / 100ps

module tb_utf16_to_utf8_encoder;

  typedef struct packed {
    logic [15:0] code;
    logic        lom;
  } utf16_unit_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } utf8_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] in_code_unit = 16'h0000;
  logic        in_last_of_message = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_utf8_byte;
  logic        out_last_byte;

  utf16_unit_t unit_q[$];
  utf8_beat_t  utf8_expected[$];
  utf16_unit_t next_unit;

  logic [9:0] held_high = 10'd0;
  logic       held_valid = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int units_in = 0;
  int bytes_out = 0;
  int pairs_seen = 0;

  utf16_to_utf8_encoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_code_unit       (in_code_unit),
    .in_last_of_message (in_last_of_message),
    .empty              (empty),
    .pop                (pop),
    .out_utf8_byte      (out_utf8_byte),
    .out_last_byte      (out_last_byte)
  );

  always #5 clk = ~clk;

  task automatic encode_unit(input logic [15:0] cu, input logic lom);
    logic [20:0] cp;
    logic [7:0]  b [4];
    int          n;
    n = 0;
    if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
      held_high  = cu[9:0];
      held_valid = 1'b1;
    end else if (cu >= 16'hDC00 && cu <= 16'hDFFF && held_valid) begin
      cp   = 21'h10000 + {1'b0, held_high, cu[9:0]};
      b[0] = 8'hF0 | {5'd0, cp[20:18]};
      b[1] = 8'h80 | {2'd0, cp[17:12]};
      b[2] = 8'h80 | {2'd0, cp[11:6]};
      b[3] = 8'h80 | {2'd0, cp[5:0]};
      n = 4;
      held_high  = 10'd0;
      held_valid = 1'b0;
      pairs_seen++;
    end else if (cu < 16'h0080) begin
      b[0] = cu[7:0];
      n = 1;
    end else if (cu < 16'h0800) begin
      b[0] = 8'hC0 | {3'd0, cu[10:6]};
      b[1] = 8'h80 | {2'd0, cu[5:0]};
      n = 2;
    end else begin
      b[0] = 8'hE0 | {4'd0, cu[15:12]};
      b[1] = 8'h80 | {2'd0, cu[11:6]};
      b[2] = 8'h80 | {2'd0, cu[5:0]};
      n = 3;
    end
    for (int i = 0; i < n; i++) utf8_expected.push_back('{val: b[i], last: (i == n - 1)});
    if (lom) begin
      held_high  = 10'd0;
      held_valid = 1'b0;
    end
  endtask

  task automatic report_error(input string msg);
    if (errors < 10) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver: hold the beat while full, refill from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_unit(in_code_unit, in_last_of_message);
        units_in++;
      end
      if (!push || !full) begin
        if (unit_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_unit = unit_q.pop_front();
          push               <= 1'b1;
          in_code_unit       <= next_unit.code;
          in_last_of_message <= next_unit.lom;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each popped byte against the oldest expected beat
  always @(posedge clk) begin
    utf8_beat_t exp_beat;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        bytes_out++;
        if (utf8_expected.size() == 0) begin
          report_error($sformatf("unexpected byte %02h last=%0b", out_utf8_byte, out_last_byte));
        end else begin
          exp_beat = utf8_expected.pop_front();
          if (out_utf8_byte !== exp_beat.val || out_last_byte !== exp_beat.last)
            report_error($sformatf("byte exp %02h last=%0b, got %02h last=%0b",
                                   exp_beat.val, exp_beat.last, out_utf8_byte, out_last_byte));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_unit(input logic [15:0] cu, input logic lom);
    unit_q.push_back('{code: cu, lom: lom});
  endtask

  task automatic add_random_units(input int count);
    int          added;
    int          pick;
    logic [15:0] v;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        queue_unit(16'($urandom_range(16'h007F)), $urandom_range(9) == 0);
        added += 1;
      end else if (pick < 30) begin
        queue_unit(16'($urandom_range(16'h07FF, 16'h0080)), $urandom_range(9) == 0);
        added += 1;
      end else if (pick < 45) begin
        v = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h0800))
                              : 16'($urandom_range(16'hFFFF, 16'hE000));
        queue_unit(v, $urandom_range(9) == 0);
        added += 1;
      end else if (pick < 75) begin
        queue_unit(16'($urandom_range(16'hDBFF, 16'hD800)), $urandom_range(15) == 0);
        queue_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(9) == 0);
        added += 2;
      end else if (pick < 82) begin
        queue_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
        v = 16'($urandom());
        if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
        queue_unit(v, 1'b0);
        queue_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(9) == 0);
        added += 3;
      end else if (pick < 88) begin
        queue_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(9) == 0);
        added += 1;
      end else if (pick < 93) begin
        queue_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
        queue_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
        queue_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), $urandom_range(9) == 0);
        added += 3;
      end else begin
        queue_unit(16'($urandom()), $urandom_range(1) == 1);
        added += 1;
      end
    end
  endtask

  task automatic drain();
    while (unit_q.size() != 0 || push || utf8_expected.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: range boundaries
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hD7FF, 1'b0);
    queue_unit(16'hE000, 1'b0);
    queue_unit(16'hFFFF, 1'b1);
    // lone low surrogates
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDFFF, 1'b0);
    // smallest and largest pairs
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b1);
    // second high overwrites the first
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hDA5A, 1'b0);
    queue_unit(16'hDE25, 1'b0);
    // plain unit between high and low keeps the high
    queue_unit(16'hD9C3, 1'b0);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'hDD3C, 1'b0);
    // end of message drops a pending high, and a plain unit carrying the flag
    queue_unit(16'hDB11, 1'b1);
    queue_unit(16'hDC77, 1'b0);
    queue_unit(16'hD8F0, 1'b0);
    queue_unit(16'h00E9, 1'b1);
    queue_unit(16'hDC01, 1'b0);

    add_random_units(75);
    drain();

    send_idle_pct = 49;
    recv_stall_pct = 0;
    add_random_units(75);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 49;
    add_random_units(78);
    drain();

    send_idle_pct = 33;
    recv_stall_pct = 33;
    add_random_units(77);
    drain();

    if (utf8_expected.size() != 0)
      report_error($sformatf("%0d expected bytes never arrived", utf8_expected.size()));

    $display("Covered %0d code units (%0d surrogate pairs), %0d UTF-8 bytes checked,",
             units_in, pairs_seen, bytes_out);
    $display("over four sender/receiver idle profiles; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("** utf16_to_utf8_encoder: PASSED **");
    end else begin
      $display("** utf16_to_utf8_encoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d bytes still expected", utf8_expected.size());
    $display("** utf16_to_utf8_encoder: FAILED **");
    $finish;
  end

endmodule

[files.f]
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_encoder.sv
dv/tb_utf16_to_utf8_encoder.sv
